>>> rtl/kts_pkg.sv
`default_nettype none
package kts_pkg;

	// default table depth
	localparam int KEYS_DEF = 64;

	// field widths
	localparam int TIME_W  = 32;
	localparam int VAL_W   = 32;
	localparam int IDX_W   = 6;
	localparam int KCNT_W  = 7;
	localparam int FRAC_W  = 16;
	localparam int ENTRY_W = TIME_W + 3 * VAL_W;

	// register indexes (byte address bit 2)
	localparam logic REG_KEY_COUNT = 1'b0;
	localparam logic REG_DURATION  = 1'b1;

	// request modes
	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

endpackage
`default_nettype wire

>>> rtl/keyframe_track_sampler.sv
`default_nettype none
// Keyframe track sampler.
// Input channel (in_valid/in_stall) carries one request: mode 0 writes one
// keyframe into table slot key_index; mode 1 sets time to (time + delta) mod
// duration (kept when it is 0) and samples the piecewise-linear track there.
// Output channel (out_valid/out_stall) returns one result per request: the
// sampled x/y/z (zero for mode 0) and the animation time after the request.
// key_count and duration are written over the APB port; the user must write
// them only while idle, as the block itself has no guard for it. A mode 0
// request lands in the output register in the cycle after it is taken. A
// mode 1 request runs the modulo (skipped when duration is zero), then the
// keyframe scan through the single-port table, then, if the time falls in a
// segment, the fraction divider (skipped for a zero-length segment) and the
// three shared-multiplier lerps, and last loads the output register.
// One request is in flight at a time; the next is taken once the result has
// been loaded and the output register is free.
// A stalled result holds in the output register; a finished request waits
// for it before loading. Reset clears the time to zero, key_count to 1 and
// duration to 0; the keyframe table has no reset and must be written first.
module keyframe_track_sampler
	import kts_pkg::*;
#(
	parameter int KEYS = KEYS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [2:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      mode,
	input  wire logic [IDX_W-1:0]          key_index,
	input  wire logic [TIME_W-1:0]         key_time,
	input  wire logic signed [VAL_W-1:0]   key_x,
	input  wire logic signed [VAL_W-1:0]   key_y,
	input  wire logic signed [VAL_W-1:0]   key_z,
	input  wire logic [TIME_W-1:0]         delta,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [VAL_W-1:0]        value_x,
	output logic signed [VAL_W-1:0]        value_y,
	output logic signed [VAL_W-1:0]        value_z,
	output logic      [TIME_W-1:0]         time_now
);

	localparam int KW = $clog2(KEYS);
	localparam int NW = KW + 1;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MOD  = 7'b0000010,
		S_SCAN = 7'b0000100,
		S_DIV  = 7'b0001000,
		S_MUL  = 7'b0010000,
		S_ADD  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [KCNT_W-1:0] kcnt_q;
	logic [TIME_W-1:0] dur_q;
	logic [TIME_W-1:0] anim_q;

	// APB registers
	logic cfg_wr;
	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			REG_KEY_COUNT: prdata = {{(32 - KCNT_W){1'b0}}, kcnt_q};
			REG_DURATION:  prdata = dur_q;
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kcnt_q <= KCNT_W'(1);
			dur_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_KEY_COUNT: kcnt_q <= pwdata[KCNT_W-1:0];
				REG_DURATION:  dur_q  <= pwdata;
				default:       ;
			endcase
		end
	end

	// effective key count, clamped to 1..KEYS
	logic [NW-1:0] n_eff;
	logic [NW-1:0] last_idx;
	always_comb begin
		if (kcnt_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(kcnt_q) > 32'(KEYS)) begin
			n_eff = NW'(KEYS);
		end else begin
			n_eff = NW'(kcnt_q);
		end
		last_idx = n_eff - NW'(1);
	end

	// request handshake
	logic out_free;
	logic in_acc;
	logic out_load;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = !((state_q == S_IDLE) && out_free);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (in_acc && (mode == MODE_WRITE)) || ((state_q == S_OUT) && out_free);

	// keyframe table: {time, x, y, z}
	logic               ram_we;
	logic [KW-1:0]      ram_addr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [NW-1:0]      rd_addr_q;

	assign ram_we   = in_acc && (mode == MODE_WRITE) && (32'(key_index) < 32'(KEYS));
	assign ram_addr = (state_q == S_IDLE) ? KW'(key_index) : rd_addr_q[KW-1:0];

	kts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(KEYS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({key_time, key_x, key_y, key_z}),
		.rdata(ram_rdata)
	);

	logic [TIME_W-1:0] d_time;
	logic [VAL_W-1:0]  d_val [3];
	assign d_time   = ram_rdata[ENTRY_W-1 -: TIME_W];
	assign d_val[0] = ram_rdata[3*VAL_W-1 -: VAL_W];
	assign d_val[1] = ram_rdata[2*VAL_W-1 -: VAL_W];
	assign d_val[2] = ram_rdata[VAL_W-1 -: VAL_W];

	// shared restoring divide step (modulo and segment fraction)
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W:0]   sh_q;
	logic [TIME_W-1:0] dvs_q;
	logic [FRAC_W:0]   q_q;
	logic [5:0]        cnt_q;
	logic [TIME_W:0]   step_r;
	logic              step_ge;
	logic [TIME_W-1:0] step_rem;
	always_comb begin
		step_r   = {rem_q, sh_q[TIME_W]};
		step_ge  = step_r >= {1'b0, dvs_q};
		step_rem = step_ge ? TIME_W'(step_r - {1'b0, dvs_q}) : step_r[TIME_W-1:0];
	end

	// scan tracking
	logic              dv_q;
	logic [NW-1:0]     didx_q;
	logic [TIME_W-1:0] prev_t_q;
	logic [VAL_W-1:0]  prev_v_q [3];
	logic [VAL_W-1:0]  v0_q [3];
	logic [VAL_W-1:0]  v1_q [3];
	logic [VAL_W-1:0]  res_q [3];

	logic [TIME_W-1:0] seg_span;
	logic [TIME_W-1:0] seg_diff;
	assign seg_span = d_time - prev_t_q;
	assign seg_diff = anim_q - prev_t_q;

	// lerp with one shared multiplier
	logic [1:0]               lane_q;
	logic signed [VAL_W:0]    lane_diff;
	logic signed [VAL_W+FRAC_W+1:0] prod_q;
	assign lane_diff = $signed({v1_q[lane_q][VAL_W-1], v1_q[lane_q]})
		- $signed({v0_q[lane_q][VAL_W-1], v0_q[lane_q]});

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_valid && !out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			anim_q    <= '0;
			dv_q      <= 1'b0;
			rd_addr_q <= '0;
			didx_q    <= '0;
			cnt_q     <= '0;
			lane_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && mode == MODE_SAMPLE) begin
						if (dur_q != '0) begin
							cnt_q   <= '0;
							state_q <= S_MOD;
						end else begin
							rd_addr_q <= '0;
							dv_q      <= 1'b0;
							state_q   <= S_SCAN;
						end
					end
				end
				S_MOD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(TIME_W)) begin
						anim_q    <= step_rem;
						rd_addr_q <= '0;
						dv_q      <= 1'b0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					logic leave;
					leave = 1'b0;
					if (dv_q) begin
						if (didx_q == '0) begin
							if (n_eff == NW'(1) || anim_q <= d_time) begin
								leave   = 1'b1;
								state_q <= S_OUT;
							end
						end else if (prev_t_q <= anim_q && anim_q <= d_time) begin
							leave   = 1'b1;
							cnt_q   <= '0;
							lane_q  <= '0;
							state_q <= (seg_span == '0) ? S_MUL : S_DIV;
						end else if (didx_q == last_idx) begin
							leave   = 1'b1;
							state_q <= S_OUT;
						end
					end
					if (leave) begin
						dv_q <= 1'b0;
					end else begin
						dv_q   <= rd_addr_q < n_eff;
						didx_q <= rd_addr_q;
						if (rd_addr_q < n_eff) begin
							rd_addr_q <= rd_addr_q + NW'(1);
						end
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(FRAC_W)) begin
						lane_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					lane_q <= lane_q + 2'd1;
					state_q <= (lane_q == 2'd2) ? S_OUT : S_MUL;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rem_q <= '0;
				dvs_q <= dur_q;
				sh_q  <= {1'b0, anim_q} + {1'b0, delta};
				if (in_acc && mode == MODE_WRITE) begin
					value_x  <= '0;
					value_y  <= '0;
					value_z  <= '0;
					time_now <= anim_q;
				end
			end
			S_MOD, S_DIV: begin
				rem_q <= step_rem;
				sh_q  <= {sh_q[TIME_W-1:0], 1'b0};
				q_q   <= {q_q[FRAC_W-1:0], step_ge};
			end
			S_SCAN: begin
				if (dv_q) begin
					prev_t_q <= d_time;
					prev_v_q <= d_val;
					res_q    <= d_val;
					v0_q     <= prev_v_q;
					v1_q     <= d_val;
					dvs_q    <= seg_span;
					rem_q    <= {1'b0, seg_diff[TIME_W-1:1]};
					sh_q     <= {seg_diff[0], {TIME_W{1'b0}}};
					q_q      <= '0;
				end
			end
			S_MUL: begin
				prod_q <= lane_diff * $signed({1'b0, q_q});
			end
			S_ADD: begin
				res_q[lane_q] <= v0_q[lane_q] + prod_q[VAL_W+FRAC_W-1:FRAC_W];
			end
			S_OUT: begin
				if (out_free) begin
					value_x  <= res_q[0];
					value_y  <= res_q[1];
					value_z  <= res_q[2];
					time_now <= anim_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/kts_ram.sv
`default_nettype none
module kts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

>>> verif/tb.sv
`default_nettype none
module tb;
	import kts_pkg::*;

	localparam int KEYS       = KEYS_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_LEN   = 400;
	localparam int SETTLE     = 130;

	typedef struct {
		logic                     mode;
		logic [IDX_W-1:0]         idx;
		logic [TIME_W-1:0]        kt;
		logic signed [VAL_W-1:0]  kx, ky, kz;
		logic [TIME_W-1:0]        dl;
	} req_t;

	typedef struct {
		logic signed [VAL_W-1:0] x, y, z;
		logic [TIME_W-1:0]       tn;
	} res_t;

	typedef struct {
		bit          is_cfg;
		logic        reg_sel;
		logic [31:0] data;
		req_t        r;
		bit          has_exp;
		res_t        e;
	} drow_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = MODE_WRITE;
	logic [IDX_W-1:0] key_index = '0;
	logic [TIME_W-1:0] key_time = '0;
	logic signed [VAL_W-1:0] key_x = '0, key_y = '0, key_z = '0;
	logic [TIME_W-1:0] delta = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [VAL_W-1:0] value_x, value_y, value_z;
	logic [TIME_W-1:0] time_now;

	keyframe_track_sampler #(.KEYS(KEYS)) i_dut (.*);

	always #5 clk = ~clk;

	// shadow of the block's state
	logic [TIME_W-1:0] shadow_time [KEYS];
	longint            shadow_val [KEYS][3];
	logic [TIME_W-1:0] shadow_now = '0;
	logic [6:0]        shadow_kc = 7'd1;
	logic [31:0]       shadow_dur = '0;

	res_t sample_q[$];
	int errors = 0;
	int n_write = 0, n_sample = 0, n_checked = 0, n_phase = 0;
	int burst_left = 0;
	bit hold_req = 1'b0;

	// floor((b - a) * t / 2^16) added to a
	function automatic logic signed [31:0] blend(longint a, longint b, longint t);
		longint p;
		p = (b - a) * t;
		return 32'(a + (p >>> 16));
	endfunction

	function automatic res_t track_predict(req_t r);
		res_t o;
		int n;
		longint unsigned span, frac, sum;
		bit found;
		o = '{x: '0, y: '0, z: '0, tn: '0};
		found = 1'b0;
		if (r.mode == MODE_WRITE) begin
			shadow_time[r.idx] = r.kt;
			shadow_val[r.idx][0] = r.kx;
			shadow_val[r.idx][1] = r.ky;
			shadow_val[r.idx][2] = r.kz;
			o.tn = shadow_now;
			return o;
		end
		if (shadow_dur != 0) begin
			sum = longint'(shadow_now) + longint'(r.dl);
			shadow_now = 32'(sum % longint'(shadow_dur));
		end
		o.tn = shadow_now;
		n = shadow_kc;
		if (n == 0) n = 1;
		if (n > KEYS) n = KEYS;
		if (n == 1 || shadow_now <= shadow_time[0]) begin
			o.x = 32'(shadow_val[0][0]);
			o.y = 32'(shadow_val[0][1]);
			o.z = 32'(shadow_val[0][2]);
			return o;
		end
		// first segment that brackets the time wins
		for (int i = 0; i + 1 < n && !found; i++) begin
			if (shadow_time[i] <= shadow_now && shadow_now <= shadow_time[i+1]) begin
				span = longint'(shadow_time[i+1]) - longint'(shadow_time[i]);
				frac = 0;
				if (span != 0)
					frac = ((longint'(shadow_now) - longint'(shadow_time[i])) << 16) / span;
				o.x = blend(shadow_val[i][0], shadow_val[i+1][0], frac);
				o.y = blend(shadow_val[i][1], shadow_val[i+1][1], frac);
				o.z = blend(shadow_val[i][2], shadow_val[i+1][2], frac);
				found = 1'b1;
			end
		end
		if (!found) begin
			o.x = 32'(shadow_val[n-1][0]);
			o.y = 32'(shadow_val[n-1][1]);
			o.z = 32'(shadow_val[n-1][2]);
		end
		return o;
	endfunction

	// offer one request, wait for it, then keep or end the burst
	task automatic send_req(req_t r, bit has_exp = 0, res_t e = '{default: '0});
		res_t p;
		@(negedge clk);
		mode <= r.mode; key_index <= r.idx; key_time <= r.kt;
		key_x <= r.kx; key_y <= r.ky; key_z <= r.kz; delta <= r.dl;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		p = track_predict(r);
		sample_q.push_back(has_exp ? e : p);
		if (r.mode == MODE_WRITE) n_write++; else n_sample++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 15)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic drain();
		if (in_valid) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		while (sample_q.size() != 0) @(posedge clk);
	endtask

	// register write while idle
	task automatic cfg_write(logic sel, logic [31:0] data);
		drain();
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {sel, 2'b00}; pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (sel == REG_KEY_COUNT) shadow_kc = data[6:0];
		else shadow_dur = data;
	endtask

	function automatic req_t mk_write(int idx, logic [31:0] t, logic [31:0] x, y, z);
		return '{mode: MODE_WRITE, idx: idx[5:0], kt: t, kx: x, ky: y, kz: z, dl: '0};
	endfunction

	function automatic req_t mk_sample(logic [31:0] d);
		return '{mode: MODE_SAMPLE, idx: '0, kt: '0, kx: '0, ky: '0, kz: '0, dl: d};
	endfunction

	function automatic drow_t row(req_t r);
		return '{is_cfg: 0, reg_sel: 0, data: 0, r: r, has_exp: 0, e: '{default: '0}};
	endfunction

	function automatic drow_t row_exp(req_t r, logic [31:0] x, y, z, tn);
		return '{is_cfg: 0, reg_sel: 0, data: 0, r: r, has_exp: 1,
			e: '{x: x, y: y, z: z, tn: tn}};
	endfunction

	function automatic drow_t row_cfg(logic sel, logic [31:0] d);
		return '{is_cfg: 1, reg_sel: sel, data: d, r: mk_sample(0), has_exp: 0,
			e: '{default: '0}};
	endfunction

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// well-formed table: ascending times, some zero-length segments
	task automatic fill_table();
		longint unsigned t, stepmax;
		stepmax = (shadow_dur == 0) ? 64'h0400_0000 : longint'(shadow_dur) / 48 + 1;
		t = $urandom_range(0, 32'(stepmax));
		for (int i = 0; i < KEYS; i++) begin
			send_req(mk_write(i, 32'(t), rnd_val(), rnd_val(), rnd_val()));
			if ($urandom_range(0, 7) != 0) t += $urandom_range(0, 32'(stepmax));
			if (t > 64'hffff_ffff) t = 64'hffff_ffff;
		end
	endtask

	// result check
	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (sample_q.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				e = sample_q.pop_front();
				n_checked++;
				if (value_x !== e.x) begin
					$error("value_x exp %h got %h", e.x, value_x); errors++;
				end
				if (value_y !== e.y) begin
					$error("value_y exp %h got %h", e.y, value_y); errors++;
				end
				if (value_z !== e.z) begin
					$error("value_z exp %h got %h", e.z, value_z); errors++;
				end
				if (time_now !== e.tn) begin
					$error("time_now exp %h got %h", e.tn, time_now); errors++;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold on request
	initial begin
		int style;
		style = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0) style = $urandom_range(0, 2);
				case (style)
					0: out_stall <= 1'b0;
					1: out_stall <= $urandom_range(0, 1);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// watchdog on stretches with no handshake
	always @(posedge clk) begin
		int idle;
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
		else idle++;
		if (idle >= IDLE_LIMIT) begin
			$display("timeout: no request moved for %0d cycles", idle);
			$display("FAIL keyframe_track_sampler");
			$finish;
		end
	end

	initial begin
		drow_t dir_tab[$];
		logic [31:0] kc_set [8];
		logic [31:0] dur_set [8];
		req_t r;
		int items;
		kc_set  = '{64, 127, 0, 1, 2, 65, 0, 64};
		dur_set = '{32'h0010_0000, 32'hffff_ffff, 32'h1, 32'h0008_0000, 0, 0, 0,
			32'h0004_0000};
		kc_set[6]  = $urandom_range(3, 40);
		dur_set[4] = $urandom;
		dur_set[6] = $urandom_range(1, 32'h00ff_ffff);
		burst_left = $urandom_range(1, 24);

		// directed: reset config, then a two-key track with lerp, end point, wrap
		dir_tab.push_back(row_exp(mk_write(0, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 0),
			0, 0, 0, 0));
		dir_tab.push_back(row_exp(mk_sample(32'hffff_ffff), 32'h7fff_ffff, 32'h8000_0000, 0, 0));
		dir_tab.push_back(row_exp(mk_write(63, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'hffff_ffff), 0, 0, 0, 0));
		dir_tab.push_back(row_exp(mk_write(1, 32'h0002_0000, 0, 0, 32'h0001_0000), 0, 0, 0, 0));
		dir_tab.push_back(row_exp(mk_sample(0), 32'h7fff_ffff, 32'h8000_0000, 0, 0));
		dir_tab.push_back(row_cfg(REG_KEY_COUNT, 2));
		dir_tab.push_back(row_cfg(REG_DURATION, 32'h0003_0000));
		dir_tab.push_back(row(mk_sample(0)));
		dir_tab.push_back(row(mk_sample(32'h0001_8000)));
		dir_tab.push_back(row(mk_sample(32'h0000_8000)));
		dir_tab.push_back(row(mk_sample(32'h0000_8000)));
		dir_tab.push_back(row(mk_sample(32'hffff_ffff)));
		// zero-length segment
		dir_tab.push_back(row(mk_write(1, 32'h0001_0000, 32'h8000_0000, 5, 6)));
		dir_tab.push_back(row(mk_sample(32'h0002_0000)));
		dir_tab.push_back(row_cfg(REG_DURATION, 32'hffff_ffff));
		dir_tab.push_back(row(mk_sample(32'hffff_ffff)));
		dir_tab.push_back(row(mk_write(1, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0)));
		dir_tab.push_back(row(mk_sample(32'h4000_0000)));
		dir_tab.push_back(row(mk_sample(32'h7fff_ffff)));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) cfg_write(dir_tab[i].reg_sel, dir_tab[i].data);
			else send_req(dir_tab[i].r, dir_tab[i].has_exp, dir_tab[i].e);
		end

		// random phases, each on a fresh ascending table
		for (int ph = 0; ph < 8; ph++) begin
			cfg_write(REG_DURATION, dur_set[ph]);
			if (ph == 0) fill_table();
			cfg_write(REG_KEY_COUNT, kc_set[ph]);
			n_phase++;
			if (ph != 0) fill_table();
			items = 180;
			for (int k = 0; k < items; k++) begin
				if (ph == 1 && k == 60) hold_req = 1'b1;
				if (ph == 2 && k == 90) drain();
				if ($urandom_range(0, 99) < 15)
					r = mk_write($urandom_range(0, KEYS - 1), $urandom, rnd_val(),
						rnd_val(), rnd_val());
				else if ($urandom_range(0, 9) == 0 || shadow_dur == 0)
					r = mk_sample($urandom);
				else
					r = mk_sample($urandom_range(0, shadow_dur / 16 + 1));
				send_req(r);
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d keyframe writes and %0d samples over %0d register settings",
			n_write, n_sample, n_phase);
		$display("%0d results checked, %0d mismatches", n_checked, errors);
		if (errors == 0 && sample_q.size() == 0)
			$display("PASS keyframe_track_sampler");
		else
			$display("FAIL keyframe_track_sampler");
		$finish;
	end

endmodule
`default_nettype wire
